// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define URA_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define URA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ura_pkg.sv =====
package ura_pkg;

  localparam int RING_W   = 13;
  localparam int SIZE_W   = 29;
  localparam int TAG_W    = 6;
  localparam int STATUS_W = 3;
  localparam int START_W  = 12;
  localparam int RETIRE_W = 7;

  localparam int MAX_UNITS_DEF     = 4096;
  localparam int PENDING_DEPTH_DEF = 64;
  localparam int UNIT_BYTES_DEF    = 65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_CMPL  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_RING_FULL       = 3'd1,
    ST_QUEUE_FULL      = 3'd2,
    ST_ZERO_SIZE       = 3'd3,
    ST_TAG_NOT_PENDING = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic pop;
    logic place;
    logic cmpl;
  } cmd_t;

  typedef struct packed {
    logic can_retire;
    logic mismatch;
  } stat_t;

endpackage

// ===== rtl/upload_ring_allocator_core.sv =====
// Ring allocator for an upload heap in whole units. Pulse start with busy low to transfer an
// allocate (in_kind 0) or completion (in_kind 1) item; busy stays high until the result.
// An allocate first retires R entries from the pending queue front, stopping on a mismatch,
// and then places the request, each retired entry needing one registered read of the
// pending-queue RAM and one compare against the ring tail. Each result is a
// one-cycle out_valid transfer and the receiver cannot stall it; busy drops in that same
// cycle, so the next start can be taken at once. Write cfg_we only while busy is low.
module upload_ring_allocator_core #(
  parameter int MAX_UNITS     = ura_pkg::MAX_UNITS_DEF,
  parameter int PENDING_DEPTH = ura_pkg::PENDING_DEPTH_DEF,
  parameter int UNIT_BYTES    = ura_pkg::UNIT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ura_pkg::RING_W-1:0]    cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [ura_pkg::SIZE_W-1:0]    in_size_bytes,
  input  logic [ura_pkg::TAG_W-1:0]     in_done_tag,
  output logic                          out_valid,
  output logic [ura_pkg::STATUS_W-1:0]  out_status,
  output logic [ura_pkg::START_W-1:0]   out_start_unit,
  output logic [ura_pkg::TAG_W-1:0]     out_grant_tag,
  output logic [ura_pkg::RETIRE_W-1:0]  out_retired,
  output logic                          out_mismatch
);
  import ura_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ura_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_kind),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  ura_dpath #(
    .MAX_UNITS    (MAX_UNITS),
    .PENDING_DEPTH(PENDING_DEPTH),
    .UNIT_BYTES   (UNIT_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_size_bytes (in_size_bytes),
    .in_done_tag   (in_done_tag),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_start_unit(out_start_unit),
    .out_grant_tag (out_grant_tag),
    .out_retired   (out_retired),
    .out_mismatch  (out_mismatch)
  );
endmodule

// ===== rtl/ura_ram.sv =====
module ura_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/ura_ctrl.sv =====
`include "assert_macros.svh"

module ura_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_kind,
  input  ura_pkg::stat_t st,
  output ura_pkg::cmd_t  cmd,
  output logic          busy
);
  import ura_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RETQ,
    S_RETC,
    S_PLACE,
    S_CMPL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_kind == KIND_CMPL) ? S_CMPL : S_RETQ;
        end
      end
      S_RETQ:  state_nxt = st.can_retire ? S_RETC : S_PLACE;
      S_RETC:  state_nxt = st.mismatch ? S_PLACE : S_RETQ;
      S_PLACE: state_nxt = S_IDLE;
      S_CMPL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = start && (state_r == S_IDLE);
    cmd.pop     = (state_r == S_RETC);
    cmd.place   = (state_r == S_PLACE);
    cmd.cmpl    = (state_r == S_CMPL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  `URA_ASSERT(a_busy_state, busy_r == (state_r != S_IDLE), "busy out of step with state")
  `URA_ASSERT_NEXT(a_mism_stop, (state_r == S_RETC) && st.mismatch, state_r == S_PLACE, "retire continued after mismatch")
endmodule

// ===== rtl/ura_dpath.sv =====
`include "assert_macros.svh"

module ura_dpath #(
  parameter int MAX_UNITS     = ura_pkg::MAX_UNITS_DEF,
  parameter int PENDING_DEPTH = ura_pkg::PENDING_DEPTH_DEF,
  parameter int UNIT_BYTES    = ura_pkg::UNIT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ura_pkg::RING_W-1:0]    cfg_wdata,
  input  logic [ura_pkg::SIZE_W-1:0]    in_size_bytes,
  input  logic [ura_pkg::TAG_W-1:0]     in_done_tag,
  input  ura_pkg::cmd_t                 cmd,
  output ura_pkg::stat_t                st,
  output logic                          out_valid,
  output logic [ura_pkg::STATUS_W-1:0]  out_status,
  output logic [ura_pkg::START_W-1:0]   out_start_unit,
  output logic [ura_pkg::TAG_W-1:0]     out_grant_tag,
  output logic [ura_pkg::RETIRE_W-1:0]  out_retired,
  output logic                          out_mismatch
);
  import ura_pkg::*;

  localparam int UW  = $clog2(MAX_UNITS + 1);
  localparam int QW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int OW  = QW + 1;
  localparam int CW  = $clog2(PENDING_DEPTH + 1);
  localparam int SH  = $clog2(UNIT_BYTES);
  localparam int NW  = SIZE_W + 1 - SH;
  localparam int RUW = (RING_W > UW) ? RING_W : UW;
  localparam int M1  = (UW > NW) ? UW : NW;
  localparam int AW  = ((M1 > RUW) ? M1 : RUW) + 1;
  localparam int TW  = ((TAG_W > QW) ? TAG_W : QW) + 1;
  localparam int EW  = 2 * UW;

  logic [RUW-1:0]          ring_units_r;
  logic [UW-1:0]           head_r, tail_r;
  logic [QW-1:0]           front_r, back_r;
  logic [CW-1:0]           count_r, retired_r;
  logic [PENDING_DEPTH-1:0] done_r;
  logic                    mism_r;
  logic [NW-1:0]           units_r;
  logic [TAG_W-1:0]        tag_r;

  logic                    out_valid_r;
  status_t                 status_r;
  logic [START_W-1:0]      start_r;
  logic [TAG_W-1:0]        grant_r;
  logic [RETIRE_W-1:0]     retired_out_r;
  logic                    mism_out_r;

  logic [SIZE_W:0]         size_rnd;
  logic [EW-1:0]           rd_data, wr_data;
  logic [UW-1:0]           ent_old, ent_new;
  logic [QW-1:0]           front_inc, back_inc;

  logic [AW-1:0]           units_a, head_a, tail_a, cap_a, ru_a, room_a;
  logic                    fit, qfull;
  logic [UW-1:0]           at_u, new_head;
  status_t                 alloc_st;
  logic                    place_ok;

  logic [TW-1:0]           t_w;
  logic [QW-1:0]           t_idx;
  logic [OW-1:0]           idx_o, front_o, off_o;
  logic                    t_pending;

  assign size_rnd = (SIZE_W + 1)'(in_size_bytes) + (SIZE_W + 1)'(UNIT_BYTES - 1);

  assign ent_old = rd_data[EW-1:UW];
  assign ent_new = rd_data[UW-1:0];

  assign front_inc = (front_r == QW'(PENDING_DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign back_inc  = (back_r == QW'(PENDING_DEPTH - 1)) ? '0 : back_r + 1'b1;

  always_comb begin
    st.can_retire = (count_r != '0) && done_r[front_r];
    st.mismatch   = (ent_old != tail_r);
  end

  // placement
  always_comb begin
    units_a = AW'(units_r);
    head_a  = AW'(head_r);
    tail_a  = AW'(tail_r);
    ru_a    = AW'(ring_units_r);
    if (ru_a == '0) begin
      cap_a = AW'(1);
    end else if (ru_a > AW'(MAX_UNITS)) begin
      cap_a = AW'(MAX_UNITS);
    end else begin
      cap_a = ru_a;
    end
    room_a = (head_a < cap_a) ? cap_a - head_a : '0;
    fit    = 1'b0;
    at_u   = head_r;
    if (tail_r > head_r) begin
      fit = (tail_a - head_a) >= units_a;
    end else if ((tail_r == head_r) && (count_r != '0)) begin
      fit = 1'b0;
    end else if (room_a >= units_a) begin
      fit = 1'b1;
    end else if (tail_a >= units_a) begin
      fit  = 1'b1;
      at_u = '0;
    end
    new_head = UW'(AW'(at_u) + units_a);
    qfull    = (count_r == CW'(PENDING_DEPTH));
    if (units_r == '0) begin
      alloc_st = ST_ZERO_SIZE;
    end else if (qfull) begin
      alloc_st = ST_QUEUE_FULL;
    end else if (!fit) begin
      alloc_st = ST_RING_FULL;
    end else begin
      alloc_st = ST_OK;
    end
    place_ok = cmd.place && (alloc_st == ST_OK);
  end

  assign wr_data = {head_r, new_head};

  // completion window check
  always_comb begin
    t_w     = TW'(tag_r);
    t_idx   = t_w[QW-1:0];
    idx_o   = OW'(t_idx);
    front_o = OW'(front_r);
    off_o   = (idx_o >= front_o) ? idx_o - front_o
                                 : idx_o + OW'(PENDING_DEPTH) - front_o;
    t_pending = (t_w < TW'(PENDING_DEPTH)) && (off_o < OW'(count_r));
  end

  ura_ram #(
    .WIDTH(EW),
    .DEPTH(PENDING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (place_ok),
    .waddr(back_r),
    .wdata(wr_data),
    .raddr(front_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_units_r <= RUW'(MAX_UNITS);
      head_r       <= '0;
      tail_r       <= '0;
      front_r      <= '0;
      back_r       <= '0;
      count_r      <= '0;
      done_r       <= '0;
      retired_r    <= '0;
      mism_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.place || cmd.cmpl;
      if (cfg_we) begin
        ring_units_r <= RUW'(cfg_wdata);
      end
      if (cmd.capture) begin
        retired_r <= '0;
        mism_r    <= 1'b0;
      end
      if (cmd.pop) begin
        front_r   <= front_inc;
        count_r   <= count_r - 1'b1;
        retired_r <= retired_r + 1'b1;
        if (st.mismatch) begin
          mism_r <= 1'b1;
        end else begin
          tail_r <= ent_new;
        end
      end
      if (place_ok) begin
        done_r[back_r] <= 1'b0;
        head_r         <= new_head;
        back_r         <= back_inc;
        count_r        <= count_r + 1'b1;
      end
      if (cmd.cmpl && t_pending) begin
        done_r[t_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      units_r <= size_rnd[SIZE_W:SH];
      tag_r   <= in_done_tag;
    end
    if (cmd.place) begin
      status_r      <= alloc_st;
      start_r       <= place_ok ? START_W'(at_u) : '0;
      grant_r       <= place_ok ? TAG_W'(back_r) : '0;
      retired_out_r <= RETIRE_W'(retired_r);
      mism_out_r    <= mism_r;
    end else if (cmd.cmpl) begin
      status_r      <= t_pending ? ST_OK : ST_TAG_NOT_PENDING;
      start_r       <= '0;
      grant_r       <= '0;
      retired_out_r <= '0;
      mism_out_r    <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_start_unit = start_r;
  assign out_grant_tag  = grant_r;
  assign out_retired    = retired_out_r;
  assign out_mismatch   = mism_out_r;

  `URA_ASSERT(a_count_max, count_r <= CW'(PENDING_DEPTH), "pending count above depth")
  `URA_ASSERT(a_head_max, AW'(head_r) <= AW'(MAX_UNITS), "head beyond ring")
  `URA_ASSERT_NEXT(a_result, cmd.place || cmd.cmpl, out_valid_r, "result transfer missing")
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ura_pkg::*;

  localparam int MAX_REQ_BYTES = 256 * 1024 * 1024;
  localparam int DEPTH = PENDING_DEPTH_DEF;

  typedef struct {
    status_t             status;
    bit [START_W-1:0]    start_unit;
    bit [TAG_W-1:0]      grant_tag;
    bit [RETIRE_W-1:0]   retired;
    bit                  mismatch;
  } grant_t;

  class grant_ledger;
    bit [RING_W-1:0]   ring_units = RING_W'(MAX_UNITS_DEF);
    bit [RING_W-1:0]   head_unit;
    bit [RING_W-1:0]   tail_unit;
    bit [RING_W-1:0]   old_head [DEPTH];
    bit [RING_W-1:0]   new_head [DEPTH];
    bit                done [DEPTH];
    bit [TAG_W-1:0]    front;
    bit [TAG_W-1:0]    back;
    bit [RETIRE_W-1:0] count;
    grant_t            awaited [$];
    int                errors;
    int                seen [8];
    int                retired_total;

    function void note_request(logic kind, logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
      grant_t          g;
      bit [TAG_W-1:0]  off;
      bit [TAG_W-1:0]  e;
      int              cap;
      int              units;
      int              room;
      int              at;
      bit              ok;
      g = '{ST_OK, '0, '0, '0, 1'b0};
      if (kind == KIND_CMPL) begin
        off = tag - front;
        if (int'(off) >= int'(count)) g.status = ST_TAG_NOT_PENDING;
        else done[tag] = 1'b1;
      end else begin
        units = (int'(size) + UNIT_BYTES_DEF - 1) / UNIT_BYTES_DEF;
        cap = (ring_units == 0) ? 1 :
              (int'(ring_units) > MAX_UNITS_DEF) ? MAX_UNITS_DEF : int'(ring_units);
        // retire finished entries from the queue front
        while (count > 0 && done[front]) begin
          e = front;
          front++;
          count--;
          g.retired++;
          if (old_head[e] != tail_unit) begin
            g.mismatch = 1'b1;
            break;
          end
          tail_unit = new_head[e];
        end
        if (units == 0) begin
          g.status = ST_ZERO_SIZE;
        end else if (int'(count) >= DEPTH) begin
          g.status = ST_QUEUE_FULL;
        end else begin
          ok = 1'b0;
          at = 0;
          if (tail_unit > head_unit) begin
            if (int'(tail_unit) - int'(head_unit) >= units) begin
              ok = 1'b1;
              at = int'(head_unit);
            end
          end else if (tail_unit != head_unit || count == 0) begin
            room = (int'(head_unit) < cap) ? cap - int'(head_unit) : 0;
            if (room >= units) begin
              ok = 1'b1;
              at = int'(head_unit);
            end else if (int'(tail_unit) >= units) begin
              ok = 1'b1;
            end
          end
          if (!ok) begin
            g.status = ST_RING_FULL;
          end else begin
            old_head[back] = head_unit;
            new_head[back] = RING_W'(at + units);
            done[back] = 1'b0;
            g.grant_tag = back;
            g.start_unit = START_W'(at);
            head_unit = RING_W'(at + units);
            back++;
            count++;
          end
        end
      end
      awaited.push_back(g);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_grant(logic [STATUS_W-1:0] status, logic [START_W-1:0] start_unit,
                              logic [TAG_W-1:0] grant_tag, logic [RETIRE_W-1:0] retired,
                              logic mismatch);
      grant_t g;
      seen[status]++;
      retired_total += int'(retired);
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got status %0d",
                 $time, status);
        return;
      end
      g = awaited.pop_front();
      compare_field("status", int'(g.status), int'(status));
      compare_field("start_unit", int'(g.start_unit), int'(start_unit));
      compare_field("grant_tag", int'(g.grant_tag), int'(grant_tag));
      compare_field("retired", int'(g.retired), int'(retired));
      compare_field("mismatch", int'(g.mismatch), int'(mismatch));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [RING_W-1:0]    cfg_wdata = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_kind = KIND_ALLOC;
  logic [SIZE_W-1:0]    in_size_bytes = '0;
  logic [TAG_W-1:0]     in_done_tag = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [START_W-1:0]   out_start_unit;
  logic [TAG_W-1:0]     out_grant_tag;
  logic [RETIRE_W-1:0]  out_retired;
  logic                 out_mismatch;

  grant_ledger ledger = new;

  upload_ring_allocator_core dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      ledger.check_grant(out_status, out_start_unit, out_grant_tag, out_retired, out_mismatch);
  end

  // called at a rising edge; returns at the edge where the transfer happened
  task automatic send_item(logic kind, logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
    start <= 1'b1;
    in_kind <= kind;
    in_size_bytes <= size;
    in_done_tag <= tag;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.note_request(kind, size, tag);
  endtask

  task automatic alloc_req(logic [SIZE_W-1:0] size);
    send_item(KIND_ALLOC, size, TAG_W'($urandom_range(0, DEPTH - 1)));
  endtask

  task automatic cmpl_req(logic [TAG_W-1:0] tag);
    send_item(KIND_CMPL, SIZE_W'($urandom_range(0, MAX_REQ_BYTES)), tag);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic set_ring(int units);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= RING_W'(units);
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.ring_units = RING_W'(units);
  endtask

  function automatic logic [SIZE_W-1:0] make_size(int max_u);
    int r;
    int u;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 7) return SIZE_W'(MAX_REQ_BYTES);
    if (r < 10) return SIZE_W'($urandom_range(0, MAX_REQ_BYTES));
    u = (max_u > 64 && $urandom_range(0, 4) != 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, max_u);
    return SIZE_W'((u - 1) * UNIT_BYTES_DEF + $urandom_range(1, UNIT_BYTES_DEF));
  endfunction

  // mostly tags near the queue front, some anywhere in the window, a few anywhere
  function automatic logic [TAG_W-1:0] pick_tag();
    int span;
    if (ledger.count == 0 || $urandom_range(0, 9) == 0)
      return TAG_W'($urandom_range(0, DEPTH - 1));
    span = ($urandom_range(0, 9) < 7 && ledger.count > 4) ? 4 : int'(ledger.count);
    return ledger.front + TAG_W'($urandom_range(0, span - 1));
  endfunction

  task automatic run_phase(int ring, int items, int cmpl_pct, int idle_pct, int max_u);
    set_ring(ring);
    repeat (items) begin
      if ($urandom_range(0, 99) < cmpl_pct) cmpl_req(pick_tag());
      else alloc_req(make_size(max_u));
      sender_gap(idle_pct);
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_ring(16);
    alloc_req('0);
    alloc_req(1);
    alloc_req(SIZE_W'(UNIT_BYTES_DEF));
    alloc_req(SIZE_W'(UNIT_BYTES_DEF + 1));
    alloc_req(SIZE_W'(MAX_REQ_BYTES));
    cmpl_req(5);
    cmpl_req(1);
    cmpl_req(1);
    alloc_req(SIZE_W'(12 * UNIT_BYTES_DEF));
    alloc_req(1);
    cmpl_req(0);
    alloc_req(SIZE_W'(2 * UNIT_BYTES_DEF));
    alloc_req(1);
    cmpl_req(63);
    cmpl_req(2);
    cmpl_req(3);
    cmpl_req(4);
    alloc_req('0);
    set_ring(1);
    alloc_req(1);
    set_ring(0);
    alloc_req(1);
    set_ring(8191);
    cmpl_req(5);
    cmpl_req(6);
    alloc_req(SIZE_W'(MAX_REQ_BYTES));

    run_phase(4096, 300, 45, 11, 64);
    run_phase(8191, 250, 8, 11, 16);
    run_phase(40, 300, 45, 55, 12);
    run_phase(1, 150, 50, 55, 2);
    run_phase(2, 100, 40, 0, 3);
    run_phase(300, 450, 40, 0, 4096);

    drain();
    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d granted, %0d ring full, %0d queue full, %0d zero size,",
             ledger.seen[ST_OK] + ledger.seen[ST_RING_FULL] + ledger.seen[ST_QUEUE_FULL] +
             ledger.seen[ST_ZERO_SIZE] + ledger.seen[ST_TAG_NOT_PENDING],
             ledger.seen[ST_OK], ledger.seen[ST_RING_FULL], ledger.seen[ST_QUEUE_FULL],
             ledger.seen[ST_ZERO_SIZE]);
    $display("%0d bad completion tags, %0d entries retired, ring sizes 0 to 8191, %0d errors",
             ledger.seen[ST_TAG_NOT_PENDING], ledger.retired_total, ledger.errors);
    if (ledger.errors == 0)
      $display("upload_ring_allocator_core regression: pass");
    else
      $display("upload_ring_allocator_core regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("upload_ring_allocator_core regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ura_pkg.sv
rtl/ura_ram.sv
rtl/ura_ctrl.sv
rtl/ura_dpath.sv
rtl/upload_ring_allocator_core.sv
tb/tb.sv
